// ----- rtl/scta_pkg.sv -----
// Shared types, key constants and the three key lookup tables of the scancode translator.
package scta_pkg;

    localparam int NumKeys = 100;

    // Flag positions in the modifier vector
    localparam int FlagRsh = 0;
    localparam int FlagLsh = 1;
    localparam int FlagCtl = 2;
    localparam int FlagAlt = 3;
    localparam int FlagCap = 4;
    localparam int FlagWidth = 5;

    // Key indexes (key number minus one) of the modifier keys
    localparam logic [6:0] KEY_LSHIFT = 7'(8'h2a - 8'd1);
    localparam logic [6:0] KEY_RSHIFT = 7'(8'h36 - 8'd1);
    localparam logic [6:0] KEY_CTRL   = 7'(8'h1d - 8'd1);
    localparam logic [6:0] KEY_ALT    = 7'(8'h38 - 8'd1);
    localparam logic [6:0] KEY_CAPS   = 7'(8'h3a - 8'd1);

    localparam logic [7:0] CHAR_DEAD  = 8'hff;
    localparam logic [7:0] CHAR_SPARE = 8'hfe;
    localparam logic [7:0] CTRL_MASK  = 8'h1f;
    localparam logic [7:0] RELEASE_BIT_MASK = 8'h80;
    localparam logic [7:0] KEY_MASK   = 8'h7f;

    // Key classes
    localparam logic [7:0] C0 = 8'h00;
    localparam logic [7:0] CS = 8'h03;
    localparam logic [7:0] CC = 8'h07;
    localparam logic [7:0] CL = 8'h17;
    localparam logic [7:0] CK = 8'h63;
    localparam logic [7:0] CM = 8'h80;

    typedef logic [FlagWidth-1:0] flags_t;

    // Modifier update request, from the translator to the flag register
    typedef struct packed {
        logic   is_mod;
        logic   release_key;
        logic   toggle;
        flags_t sel;
    } mod_evt_t;

    localparam logic [7:0] LOW_ROM [0:NumKeys-1] = '{
        8'h1b,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,
        8'h37,8'h38,8'h39,8'h30,8'h2d,8'h3d,8'h08,8'h09,
        8'h71,8'h77,8'h65,8'h72,8'h74,8'h79,8'h75,8'h69,
        8'h6f,8'h70,8'h5b,8'h5d,8'h0d,8'hff,8'h61,8'h73,
        8'h64,8'h66,8'h67,8'h68,8'h6a,8'h6b,8'h6c,8'h3b,
        8'h27,8'h60,8'hff,8'h5c,8'h7a,8'h78,8'h63,8'h76,
        8'h62,8'h6e,8'h6d,8'h2c,8'h2e,8'h2f,8'hff,8'hfe,
        8'hff,8'h20,8'hff,8'h81,8'h82,8'h83,8'h84,8'h85,
        8'h86,8'h87,8'h88,8'h89,8'h8a,8'hfe,8'hfe,8'h01,
        8'h10,8'h1a,8'h2d,8'h02,8'hfe,8'h06,8'h2b,8'h05,
        8'h0e,8'h16,8'hfe,8'h7f,8'h8b,8'h7f,8'hfe,8'hfe,
        8'hfe,8'hfe,8'h8c,8'h8d,8'h8e,8'h8f,8'h0d,8'h8b,
        8'hfe,8'hfe,8'hfe,8'hff,8'hff
    };

    localparam logic [7:0] UP_ROM [0:NumKeys-1] = '{
        8'h1b,8'h21,8'h40,8'h23,8'h24,8'h25,8'h5e,
        8'h26,8'h2a,8'h28,8'h29,8'h5f,8'h2b,8'h08,8'h09,
        8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,
        8'h4f,8'h50,8'h7b,8'h7d,8'h0d,8'hff,8'h41,8'h53,
        8'h44,8'h46,8'h47,8'h48,8'h4a,8'h4b,8'h4c,8'h3a,
        8'h22,8'h7e,8'hff,8'h7c,8'h5a,8'h58,8'h43,8'h56,
        8'h42,8'h4e,8'h4d,8'h3c,8'h3e,8'h3f,8'hff,8'hfe,
        8'hff,8'h20,8'hff,8'h81,8'h82,8'h83,8'h84,8'h85,
        8'h86,8'h87,8'h88,8'h89,8'h8a,8'hfe,8'hfe,8'h01,
        8'h10,8'h1a,8'h2d,8'h02,8'hfe,8'h06,8'h2b,8'h05,
        8'h0e,8'h16,8'hfe,8'h7f,8'h8b,8'h7f,8'hfe,8'hfe,
        8'hfe,8'hfe,8'h8c,8'h8d,8'h8e,8'h8f,8'h0d,8'h8b,
        8'hfe,8'hfe,8'hfe,8'hff,8'hff
    };

    localparam logic [7:0] CLASS_ROM [0:NumKeys-1] = '{
        C0,CS,CC,CS,CS,CS,CC,
        CS,CS,CS,CS,CC,CS,C0,C0,
        CL,CL,CL,CL,CL,CL,CL,CL,
        CL,CL,CC,CC,C0,CM,CL,CL,
        CL,CL,CL,CL,CL,CL,CL,CS,
        CS,CC,CM,CC,CL,CL,CL,CL,
        CL,CL,CL,CS,CS,CS,CM,C0,
        CM,CC,CM,C0,C0,C0,C0,C0,
        C0,C0,C0,C0,C0,C0,CK,CK,
        CK,CK,C0,CK,CK,CK,C0,CK,
        CK,CK,CK,CK,C0,C0,C0,C0,
        C0,C0,C0,C0,C0,C0,C0,C0,
        C0,C0,C0,CL,CL
    };

endpackage

// ----- rtl/scta_translate.sv -----
// Table lookup and character selection for one registered scancode.
module scta_translate
    import scta_pkg::*;
(
    input  logic [7:0] scancode,
    input  flags_t     flags,
    output logic [7:0] char_code,
    output logic       char_valid,
    output mod_evt_t   mod_evt
);

    logic [6:0] key;
    logic [6:0] idx;
    logic       in_range;
    logic       release_key;
    logic [7:0] cls;
    logic [7:0] low_code;
    logic [7:0] up_code;
    flags_t     sel;
    logic       shifted;
    logic       alt_case;
    logic       ctrl_ok;
    logic [7:0] ch;

    assign key         = 7'(scancode & KEY_MASK);
    assign release_key = |(scancode & RELEASE_BIT_MASK);
    assign in_range    = (key != 7'd0) && (key <= 7'(NumKeys));
    // park the index at zero for keys off the table
    assign idx         = in_range ? (key - 7'd1) : 7'd0;

    assign cls      = CLASS_ROM[idx];
    assign low_code = LOW_ROM[idx];
    assign up_code  = UP_ROM[idx];

    assign sel      = cls[FlagWidth-1:0] & flags;
    assign shifted  = flags[FlagRsh] | flags[FlagLsh];
    assign alt_case = sel[FlagCap];
    assign ctrl_ok  = (cls == CC) || (cls == CL);

    always_comb
    begin
        if (flags[FlagCtl])
        begin
            ch = up_code & CTRL_MASK;
        end
        else if (sel != '0)
        begin
            if (shifted)
            begin
                ch = alt_case ? low_code : up_code;
            end
            else
            begin
                ch = alt_case ? up_code : low_code;
            end
        end
        else
        begin
            ch = low_code;
        end
    end

    assign char_code  = ch;
    assign char_valid = in_range && !cls[7] && !release_key
                        && (!flags[FlagCtl] || ctrl_ok)
                        && (ch != CHAR_DEAD) && (ch != CHAR_SPARE);

    always_comb
    begin
        mod_evt             = '0;
        mod_evt.is_mod      = in_range && cls[7];
        mod_evt.release_key = release_key;
        unique case (idx)
            KEY_RSHIFT: mod_evt.sel[FlagRsh] = 1'b1;
            KEY_LSHIFT: mod_evt.sel[FlagLsh] = 1'b1;
            KEY_CTRL:   mod_evt.sel[FlagCtl] = 1'b1;
            KEY_ALT:    mod_evt.sel[FlagAlt] = 1'b1;
            KEY_CAPS:
            begin
                mod_evt.sel[FlagCap] = 1'b1;
                mod_evt.toggle       = 1'b1;
            end
            default:    mod_evt.sel = '0;
        endcase
    end

endmodule

// ----- rtl/scta_modifiers.sv -----
// Modifier flag register: shift, ctrl and alt follow press and release, caps toggles.
module scta_modifiers
    import scta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  mod_evt_t mod_evt,
    output flags_t   flags
);

    flags_t flags_reg;
    flags_t flags_next;

    always_comb
    begin
        flags_next = flags_reg;
        if (advance && mod_evt.is_mod)
        begin
            if (mod_evt.toggle)
            begin
                // caps release does nothing
                if (!mod_evt.release_key)
                begin
                    flags_next = flags_reg ^ mod_evt.sel;
                end
            end
            else if (mod_evt.release_key)
            begin
                flags_next = flags_reg & ~mod_evt.sel;
            end
            else
            begin
                flags_next = flags_reg | mod_evt.sel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

// ----- rtl/scancode_to_ascii_translator_top.sv -----
// Top level of the keyboard scancode to character translator.
//
// Input stream: one raw scancode byte per transfer on s_tdata; bit 7 set
// marks a key release. Output stream: one character byte per transfer on
// m_tdata, either ASCII or a function-key code 0x81..0x8f.
// A scancode gives at most one character. Releases, modifier keys (shift,
// ctrl, alt, caps lock), unknown keys and dead table entries give none; the
// modifier keys only update the internal modifier flags.
// Each scancode is captured in an input register, translated by the table
// lookup logic, which is combinational, and written to the output register,
// from which its character is shown on m_tdata with m_tvalid set.
// The lookup tables are constant logic. One scancode is taken every cycle
// until the receiver stalls: the output register then holds its character
// and the input register keeps accepting until it too holds a waiting
// scancode; then s_tready falls until m_tready returns.
// Reset empties both registers and releases all modifiers, caps lock off.
module scancode_to_ascii_translator_top
    import scta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] scancode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] char_code
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_code_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic       advance;
    logic [7:0] char_code;
    logic       char_valid;
    mod_evt_t   mod_evt;
    flags_t     flags;

    // move the held scancode on when the output slot is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    scta_translate u_translate (
        .scancode   (in_code_reg),
        .flags      (flags),
        .char_code  (char_code),
        .char_valid (char_valid),
        .mod_evt    (mod_evt)
    );

    scta_modifiers u_modifiers (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance && in_valid_reg),
        .mod_evt (mod_evt),
        .flags   (flags)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        if (advance)
        begin
            out_valid_next = in_valid_reg && char_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_code_reg <= s_tdata;
        end
        if (advance && in_valid_reg && char_valid)
        begin
            out_char_reg <= char_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;

endmodule
